/* design/ctpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctpc_pkg - shared constants of the color tagged point centroid core
// Field positions of a target word, result width and default sizes.
// ----------------------------------------------------------------------------
package ctpc_pkg;

    // default sizing of the core
    localparam int DEF_MAX_TARGETS = 64;
    localparam int DEF_FRAC_BITS   = 4;

    // target word layout
    localparam int WORD_W    = 32;
    localparam int COORD_W   = 12;
    localparam int X_LSB     = 0;
    localparam int Y_LSB     = 16;
    localparam int BLUE_BIT  = 28;
    localparam int RED_BIT   = 30;

    // result fields
    localparam int          MEAN_W   = 16;
    localparam logic [15:0] MEAN_MAX = 16'hFFFF;

    // number of means per frame and queue depth between front and back
    localparam int NUM_MEANS   = 4;
    localparam int QUEUE_DEPTH = 2;

    // mean codes, in result order
    localparam logic [1:0] MEAN_BLUE_X = 2'd0;
    localparam logic [1:0] MEAN_BLUE_Y = 2'd1;
    localparam logic [1:0] MEAN_RED_X  = 2'd2;
    localparam logic [1:0] MEAN_RED_Y  = 2'd3;

endpackage

/* design/ctpc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctpc_front - target word accumulator
// Classifies each word by its color flags, sums coordinates and counts per
// color, and pushes one frame record into the queue on the last word.
// ----------------------------------------------------------------------------
module ctpc_front
    import ctpc_pkg::*;
#(
    parameter int MAX_TARGETS = DEF_MAX_TARGETS,
    parameter int CW          = $clog2(MAX_TARGETS + 1),
    parameter int SW          = COORD_W + CW,
    parameter int REC_W       = 4 * SW + 2 * CW
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WORD_W-1:0] target_word,
    input  logic              last_target,
    input  logic              target_valid,
    output logic              target_stall,
    input  logic              queue_full,
    output logic              push,
    output logic [REC_W-1:0]  push_data
);

    logic [SW-1:0] blue_sum_x_reg, blue_sum_x_next;
    logic [SW-1:0] blue_sum_y_reg, blue_sum_y_next;
    logic [CW-1:0] blue_tally_reg, blue_tally_next;
    logic [SW-1:0] red_sum_x_reg,  red_sum_x_next;
    logic [SW-1:0] red_sum_y_reg,  red_sum_y_next;
    logic [CW-1:0] red_tally_reg,  red_tally_next;
    logic [CW-1:0] seen_reg,       seen_next;

    logic [SW-1:0] blue_sum_x_acc, blue_sum_y_acc, red_sum_x_acc, red_sum_y_acc;
    logic [CW-1:0] blue_tally_acc, red_tally_acc, seen_acc;
    logic [SW-1:0] x_ext, y_ext;
    logic          accept, room, add_blue, add_red;

    // word is taken only while the queue can hold a frame record
    assign target_stall = queue_full;
    assign accept       = target_valid && !queue_full;

    // classify
    assign room     = seen_reg < CW'(MAX_TARGETS);
    assign add_blue = room && target_word[BLUE_BIT];
    assign add_red  = room && target_word[RED_BIT];
    assign x_ext    = SW'(target_word[X_LSB +: COORD_W]);
    assign y_ext    = SW'(target_word[Y_LSB +: COORD_W]);

    // accumulate including the current word
    always_comb
    begin
        blue_sum_x_acc = blue_sum_x_reg + (add_blue ? x_ext : '0);
        blue_sum_y_acc = blue_sum_y_reg + (add_blue ? y_ext : '0);
        blue_tally_acc = blue_tally_reg + (add_blue ? CW'(1) : '0);
        red_sum_x_acc  = red_sum_x_reg + (add_red ? x_ext : '0);
        red_sum_y_acc  = red_sum_y_reg + (add_red ? y_ext : '0);
        red_tally_acc  = red_tally_reg + (add_red ? CW'(1) : '0);
        seen_acc       = seen_reg + (room ? CW'(1) : '0);
    end

    // frame record goes out on the last word
    assign push      = accept && last_target;
    assign push_data = {blue_sum_x_acc, blue_sum_y_acc, blue_tally_acc,
                        red_sum_x_acc, red_sum_y_acc, red_tally_acc};

    // next state: hold, accumulate or clear at frame end
    always_comb
    begin
        blue_sum_x_next = blue_sum_x_reg;
        blue_sum_y_next = blue_sum_y_reg;
        blue_tally_next = blue_tally_reg;
        red_sum_x_next  = red_sum_x_reg;
        red_sum_y_next  = red_sum_y_reg;
        red_tally_next  = red_tally_reg;
        seen_next       = seen_reg;
        if (push)
        begin
            blue_sum_x_next = '0;
            blue_sum_y_next = '0;
            blue_tally_next = '0;
            red_sum_x_next  = '0;
            red_sum_y_next  = '0;
            red_tally_next  = '0;
            seen_next       = '0;
        end
        else if (accept)
        begin
            blue_sum_x_next = blue_sum_x_acc;
            blue_sum_y_next = blue_sum_y_acc;
            blue_tally_next = blue_tally_acc;
            red_sum_x_next  = red_sum_x_acc;
            red_sum_y_next  = red_sum_y_acc;
            red_tally_next  = red_tally_acc;
            seen_next       = seen_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blue_sum_x_reg <= '0;
            blue_sum_y_reg <= '0;
            blue_tally_reg <= '0;
            red_sum_x_reg  <= '0;
            red_sum_y_reg  <= '0;
            red_tally_reg  <= '0;
            seen_reg       <= '0;
        end
        else
        begin
            blue_sum_x_reg <= blue_sum_x_next;
            blue_sum_y_reg <= blue_sum_y_next;
            blue_tally_reg <= blue_tally_next;
            red_sum_x_reg  <= red_sum_x_next;
            red_sum_y_reg  <= red_sum_y_next;
            red_tally_reg  <= red_tally_next;
            seen_reg       <= seen_next;
        end
    end

endmodule

/* design/ctpc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctpc_queue - frame record queue
// Short register queue that lets the accumulator and the divide sequencer
// stall independently.
// ----------------------------------------------------------------------------
module ctpc_queue
    import ctpc_pkg::*;
#(
    parameter int REC_W = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [REC_W-1:0] push_data,
    input  logic             pop,
    output logic [REC_W-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [REC_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/ctpc_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctpc_divider - bit serial restoring divider
// One quotient bit per cycle; the quotient saturates to the 16-bit mean.
// ----------------------------------------------------------------------------
module ctpc_divider
    import ctpc_pkg::*;
#(
    parameter int NW = 24,
    parameter int CW = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NW-1:0]     num,
    input  logic [CW-1:0]     den,
    output logic              done,
    output logic [MEAN_W-1:0] quot
);

    localparam int CNT_W = $clog2(NW + 1);
    localparam int QW    = (NW > MEAN_W) ? NW : MEAN_W;

    logic [NW-1:0]    n_reg, n_next;
    logic [CW-1:0]    r_reg, r_next;
    logic [CW-1:0]    d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [CW:0]      trial, diff;
    logic             ge;
    logic [QW-1:0]    q_ext;

    // one restoring step
    assign trial = {r_reg, n_reg[NW-1]};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_comb
    begin
        n_next    = n_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next   = {n_reg[NW-2:0], ge};
            r_next   = ge ? diff[CW-1:0] : trial[CW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    // saturate the quotient to the mean width
    assign q_ext = QW'(n_reg);
    assign quot  = ((q_ext >> MEAN_W) != '0) ? MEAN_MAX : q_ext[MEAN_W-1:0];
    assign done  = done_reg;

endmodule

/* design/ctpc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctpc_back - centroid divide sequencer
// Pops a frame record, runs the four means through the shared divider and
// hands the result word to the output register.
// ----------------------------------------------------------------------------
module ctpc_back
    import ctpc_pkg::*;
#(
    parameter int MAX_TARGETS = DEF_MAX_TARGETS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int CW          = $clog2(MAX_TARGETS + 1),
    parameter int SW          = COORD_W + CW,
    parameter int REC_W       = 4 * SW + 2 * CW
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_empty,
    input  logic [REC_W-1:0]  pop_data,
    output logic              pop,
    output logic [MEAN_W-1:0] blue_x,
    output logic [MEAN_W-1:0] blue_y,
    output logic [MEAN_W-1:0] red_x,
    output logic [MEAN_W-1:0] red_y,
    output logic              blue_found,
    output logic              red_found,
    output logic              result_valid,
    input  logic              result_stall
);

    localparam int NW = SW + FRAC_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        idx_reg, idx_next;
    logic [REC_W-1:0]  rec_reg;
    logic [MEAN_W-1:0] res_reg [NUM_MEANS];
    logic              out_valid_reg, out_valid_next;
    logic [MEAN_W-1:0] blue_x_reg, blue_y_reg, red_x_reg, red_y_reg;
    logic              blue_found_reg, red_found_reg;

    logic [SW-1:0]     r_blue_sx, r_blue_sy, r_red_sx, r_red_sy;
    logic [CW-1:0]     r_blue_n, r_red_n;
    logic [SW-1:0]     sel_sum;
    logic [CW-1:0]     sel_den;
    logic [NW-1:0]     div_num;
    logic              div_start, div_done, load_out;
    logic [MEAN_W-1:0] div_quot, mean_val;

    // unpack the frame record
    assign {r_blue_sx, r_blue_sy, r_blue_n, r_red_sx, r_red_sy, r_red_n} = rec_reg;

    // operand select for the current mean
    always_comb
    begin
        unique case (idx_reg)
            MEAN_BLUE_X: sel_sum = r_blue_sx;
            MEAN_BLUE_Y: sel_sum = r_blue_sy;
            MEAN_RED_X:  sel_sum = r_red_sx;
            MEAN_RED_Y:  sel_sum = r_red_sy;
            default:     sel_sum = r_blue_sx;
        endcase
    end
    assign sel_den = idx_reg[1] ? r_red_n : r_blue_n;
    assign div_num = NW'(sel_sum) << FRAC_BITS;

    ctpc_divider #(
        .NW (NW),
        .CW (CW)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (sel_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // an empty color gives a zero mean
    assign mean_val = (sel_den == '0) ? '0 : div_quot;

    // output slot free or being taken this cycle
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !result_stall);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    idx_next   = MEAN_BLUE_X;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    if (idx_reg == MEAN_RED_Y)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= MEAN_BLUE_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rec_reg <= pop_data;
        end
        if ((state_reg == ST_WAIT) && div_done)
        begin
            res_reg[idx_reg] <= mean_val;
        end
        if (load_out)
        begin
            blue_x_reg     <= res_reg[MEAN_BLUE_X];
            blue_y_reg     <= res_reg[MEAN_BLUE_Y];
            red_x_reg      <= res_reg[MEAN_RED_X];
            red_y_reg      <= res_reg[MEAN_RED_Y];
            blue_found_reg <= r_blue_n != '0;
            red_found_reg  <= r_red_n != '0;
        end
    end

    assign blue_x       = blue_x_reg;
    assign blue_y       = blue_y_reg;
    assign red_x        = red_x_reg;
    assign red_y        = red_y_reg;
    assign blue_found   = blue_found_reg;
    assign red_found    = red_found_reg;
    assign result_valid = out_valid_reg;

endmodule

/* design/color_tagged_point_centroid_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_tagged_point_centroid_core - blue and red target centroids per frame
// Accumulates target words of a frame and reports both color centroids.
// ----------------------------------------------------------------------------
// Usage:
//   Target channel: target_word, last_target, target_valid, target_stall.
//   One word is taken per cycle while target_stall is low; last_target
//   marks the frame's final word. Result channel: blue_x, blue_y, red_x,
//   red_y, blue_found, red_found, result_valid, result_stall; one result
//   word per frame, held while result_stall is high.
//   Means are unsigned with FRAC_BITS fraction bits, truncated, saturated
//   to 16 bits; a color with no targets reports 0 and found low. Words past
//   MAX_TARGETS in a frame are ignored.
//   One serial divider runs the four means in turn, one quotient bit per
//   cycle, N = 12 + clog2(MAX_TARGETS+1) + FRAC_BITS bits each. One word
//   is taken per cycle while target_stall is low. A two-entry frame queue
//   sits between the accumulator and the divider; target_stall rises only
//   when two finished frames are waiting there, which happens for frames
//   shorter than the divide time or while result_stall holds the output.
//   A stalled result does not block the next frame's divides.
//   Reset clears all sums, the queue and the output valid.
// ----------------------------------------------------------------------------
module color_tagged_point_centroid_core
    import ctpc_pkg::*;
#(
    parameter int MAX_TARGETS = DEF_MAX_TARGETS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WORD_W-1:0] target_word,
    input  logic              last_target,
    input  logic              target_valid,
    output logic              target_stall,
    output logic [MEAN_W-1:0] blue_x,
    output logic [MEAN_W-1:0] blue_y,
    output logic [MEAN_W-1:0] red_x,
    output logic [MEAN_W-1:0] red_y,
    output logic              blue_found,
    output logic              red_found,
    output logic              result_valid,
    input  logic              result_stall
);

    localparam int CW    = $clog2(MAX_TARGETS + 1);
    localparam int SW    = COORD_W + CW;
    localparam int REC_W = 4 * SW + 2 * CW;

    logic             push, pop, queue_full, queue_empty;
    logic [REC_W-1:0] push_data, pop_data;

    ctpc_front #(
        .MAX_TARGETS (MAX_TARGETS),
        .CW          (CW),
        .SW          (SW),
        .REC_W       (REC_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .target_word  (target_word),
        .last_target  (last_target),
        .target_valid (target_valid),
        .target_stall (target_stall),
        .queue_full   (queue_full),
        .push         (push),
        .push_data    (push_data)
    );

    ctpc_queue #(
        .REC_W (REC_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    ctpc_back #(
        .MAX_TARGETS (MAX_TARGETS),
        .FRAC_BITS   (FRAC_BITS),
        .CW          (CW),
        .SW          (SW),
        .REC_W       (REC_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .blue_x       (blue_x),
        .blue_y       (blue_y),
        .red_x        (red_x),
        .red_y        (red_y),
        .blue_found   (blue_found),
        .red_found    (red_found),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

/* tb/color_tagged_point_centroid_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_tagged_point_centroid_core_test - frame centroid checker
// Streams framed target words into the core and checks each frame's blue
// and red centroids and found flags against an in-bench centroid predictor.
// Target words see random idle gaps, results a random stall pattern.
// ----------------------------------------------------------------------------
module color_tagged_point_centroid_core_test;
    import ctpc_pkg::*;

    localparam int SUM_W       = COORD_W + $clog2(DEF_MAX_TARGETS);
    localparam int CNT_W       = $clog2(DEF_MAX_TARGETS + 1);
    localparam int DIV_BITS    = COORD_W + CNT_W + DEF_FRAC_BITS;
    localparam int DRAIN_WAIT  = 4 * (DIV_BITS + 2) + 3 + 50;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [COORD_W-1:0] COORD_MAX = '1;

    typedef struct packed {
        logic [MEAN_W-1:0] bx;
        logic [MEAN_W-1:0] by;
        logic [MEAN_W-1:0] rx;
        logic [MEAN_W-1:0] ry;
        logic              bf;
        logic              rf;
    } centroid_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic [WORD_W-1:0] target_word = '0;
    logic              last_target = 1'b0;
    logic              target_valid = 1'b0;
    logic              target_stall;
    logic [MEAN_W-1:0] blue_x;
    logic [MEAN_W-1:0] blue_y;
    logic [MEAN_W-1:0] red_x;
    logic [MEAN_W-1:0] red_y;
    logic              blue_found;
    logic              red_found;
    logic              result_valid;
    logic              result_stall = 1'b0;

    // predictor state: running sums for the current frame
    logic [SUM_W-1:0]  blue_sx, blue_sy, red_sx, red_sy;
    logic [CNT_W-1:0]  blue_cnt, red_cnt, words_in_frame;
    centroid_t         centroid_q[$];

    int                err_count = 0;
    int                cycle_count = 0;
    int                burst_left = 0;
    int                stall_window = 0;
    int                stall_mode = 0;

    color_tagged_point_centroid_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .target_word  (target_word),
        .last_target  (last_target),
        .target_valid (target_valid),
        .target_stall (target_stall),
        .blue_x       (blue_x),
        .blue_y       (blue_y),
        .red_x        (red_x),
        .red_y        (red_y),
        .blue_found   (blue_found),
        .red_found    (red_found),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // truncated fixed-point mean, saturated to the result width
    function automatic logic [MEAN_W-1:0] fixed_mean(logic [SUM_W-1:0] sum,
                                                     logic [CNT_W-1:0] cnt);
        logic [SUM_W+DEF_FRAC_BITS-1:0] scaled;
        logic [SUM_W+DEF_FRAC_BITS-1:0] quot;
        if (cnt == 0)
            return '0;
        scaled = sum;
        scaled = scaled << DEF_FRAC_BITS;
        quot   = scaled / cnt;
        return (quot > MEAN_MAX) ? MEAN_MAX : quot[MEAN_W-1:0];
    endfunction

    function automatic void clear_sums();
        blue_sx = '0; blue_sy = '0; blue_cnt = '0;
        red_sx  = '0; red_sy  = '0; red_cnt  = '0;
        words_in_frame = '0;
    endfunction

    // fold one accepted word into the frame sums; a last word closes the frame
    function automatic void absorb_target(logic [WORD_W-1:0] w, logic last);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        centroid_t          c;
        x = w[X_LSB +: COORD_W];
        y = w[Y_LSB +: COORD_W];
        if (words_in_frame < DEF_MAX_TARGETS) begin
            if (w[BLUE_BIT]) begin
                blue_sx  += x;
                blue_sy  += y;
                blue_cnt += 1'b1;
            end
            if (w[RED_BIT]) begin
                red_sx  += x;
                red_sy  += y;
                red_cnt += 1'b1;
            end
            words_in_frame += 1'b1;
        end
        if (last) begin
            c.bx = fixed_mean(blue_sx, blue_cnt);
            c.by = fixed_mean(blue_sy, blue_cnt);
            c.rx = fixed_mean(red_sx, red_cnt);
            c.ry = fixed_mean(red_sy, red_cnt);
            c.bf = (blue_cnt != 0);
            c.rf = (red_cnt != 0);
            centroid_q.push_back(c);
            clear_sums();
        end
    endfunction

    // pack a target word; junk fills the don't-care bits
    function automatic logic [WORD_W-1:0] pack_target(logic [COORD_W-1:0] x,
                                                      logic [COORD_W-1:0] y,
                                                      logic blue, logic red,
                                                      logic [WORD_W-1:0] junk);
        logic [WORD_W-1:0] w;
        w = junk;
        w[X_LSB +: COORD_W] = x;
        w[Y_LSB +: COORD_W] = y;
        w[BLUE_BIT] = blue;
        w[RED_BIT]  = red;
        return w;
    endfunction

    // coordinate with extra weight on the ends of the range
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return COORD_MAX;
            default: return $urandom;
        endcase
    endfunction

    // send one word; bursts of random length with random gaps between them
    task automatic send_target(logic [WORD_W-1:0] w, logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                target_valid <= 1'b0;
                target_word  <= $urandom;
                last_target  <= $urandom;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        target_word  <= w;
        last_target  <= last;
        target_valid <= 1'b1;
        @(posedge clk);
        while (target_stall)
            @(posedge clk);
        absorb_target(w, last);
    endtask

    // one frame of random targets with given color odds (percent)
    task automatic send_frame(int len, int blue_pct, int red_pct);
        logic [WORD_W-1:0] w;
        for (int i = 0; i < len; i++) begin
            w = pack_target(pick_coord(), pick_coord(),
                            $urandom_range(0, 99) < blue_pct,
                            $urandom_range(0, 99) < red_pct, $urandom);
            send_target(w, i == len - 1);
        end
    endtask

    // single-word frames at the coordinate extremes, each flag mix
    task automatic test_lone_targets();
        send_target(pack_target(COORD_MAX, COORD_MAX, 1'b1, 1'b0, '1), 1'b1);
        send_target(pack_target('0, '0, 1'b0, 1'b1, '0), 1'b1);
        send_target(pack_target(COORD_MAX, '0, 1'b1, 1'b1, '0), 1'b1);
        send_target(pack_target('0, COORD_MAX, 1'b1, 1'b1, '1), 1'b1);
        // no color at all: both found flags low, means zero
        send_target(pack_target(12'h5A5, 12'hA5A, 1'b0, 1'b0, '1), 1'b1);
    endtask

    // small frames where truncation of the mean shows in the fraction bits
    task automatic test_mixed_frames();
        send_target(pack_target(12'd1, 12'd2, 1'b1, 1'b0, '0), 1'b0);
        send_target(pack_target(12'd2, 12'd7, 1'b1, 1'b1, '0), 1'b0);
        send_target(pack_target(12'd9, 12'd0, 1'b0, 1'b1, '1), 1'b0);
        send_target(pack_target(12'd3, 12'd3, 1'b0, 1'b0, '1), 1'b0);
        send_target(pack_target(12'd4, 12'd5, 1'b0, 1'b1, '0), 1'b1);
        // blue only, three words: mean of 1,1,2 is not exact
        send_target(pack_target(12'd1, COORD_MAX, 1'b1, 1'b0, '0), 1'b0);
        send_target(pack_target(12'd1, COORD_MAX, 1'b1, 1'b0, '0), 1'b0);
        send_target(pack_target(12'd2, 12'd4094, 1'b1, 1'b0, '0), 1'b1);
        // red only
        send_target(pack_target(COORD_MAX, 12'd1, 1'b0, 1'b1, '0), 1'b0);
        send_target(pack_target(12'd4094, 12'd0, 1'b0, 1'b1, '0), 1'b1);
    endtask

    // frames at and past the word limit; late words must be ignored
    task automatic test_frame_limit();
        send_frame(DEF_MAX_TARGETS, 100, 100);
        send_frame(DEF_MAX_TARGETS + 1, 60, 60);
        send_frame(DEF_MAX_TARGETS + 8, 50, 50);
        send_frame(DEF_MAX_TARGETS + 3, 0, 100);
    endtask

    // runs of very short frames fill the frame queue and raise target_stall
    task automatic test_short_frames();
        for (int f = 0; f < 150; f++)
            send_frame($urandom_range(1, 2), 50, 50);
    endtask

    // random frames; mostly within the limit, some past it
    task automatic test_random_frames();
        int sent;
        int len;
        int bp;
        int rp;
        sent = 0;
        while (sent < 850) begin
            if ($urandom_range(0, 99) < 12)
                len = $urandom_range(DEF_MAX_TARGETS + 1, DEF_MAX_TARGETS + 16);
            else if ($urandom_range(0, 1) == 0)
                len = $urandom_range(1, 8);
            else
                len = $urandom_range(1, DEF_MAX_TARGETS);
            case ($urandom_range(0, 5))
                0: begin bp = 0;   rp = $urandom_range(0, 100); end
                1: begin bp = $urandom_range(0, 100); rp = 0;   end
                2: begin bp = 100; rp = 100; end
                default: begin bp = $urandom_range(0, 100); rp = $urandom_range(0, 100); end
            endcase
            send_frame(len, bp, rp);
            sent += len;
        end
    endtask

    task automatic check_field(string name, logic [MEAN_W-1:0] want,
                               logic [MEAN_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // compare one accepted result word with the oldest predicted centroid
    task automatic check_result();
        centroid_t want;
        if (centroid_q.size() == 0) begin
            $error("result word with no frame pending");
            err_count++;
        end
        else begin
            want = centroid_q.pop_front();
            check_field("blue_x", want.bx, blue_x);
            check_field("blue_y", want.by, blue_y);
            check_field("red_x", want.rx, red_x);
            check_field("red_y", want.ry, red_y);
            check_field("blue_found", want.bf, blue_found);
            check_field("red_found", want.rf, red_found);
        end
    endtask

    // result side: check accepted words, stall on a windowed random pattern
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            check_result();
        if (stall_window == 0) begin
            stall_mode   = $urandom_range(0, 3);
            stall_window = $urandom_range(40, 400);
        end
        else begin
            stall_window--;
        end
        case (stall_mode)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 99) < 35);
            2: result_stall <= ($urandom_range(0, 99) < 85);
            default: result_stall <= (stall_window % 24) < 16;
        endcase
    end

    // run time guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        clear_sums();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_lone_targets();
        test_mixed_frames();
        test_frame_limit();
        test_short_frames();
        test_random_frames();

        target_valid <= 1'b0;
        while (centroid_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_count == 0 && centroid_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
